// ----- hdl/hid_keyboard_report_to_key_events_assert.svh -----
// Assertion macros for the port checker of the keyboard report decoder.
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_ASSERT_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HKRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HKRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/hkre_pkg.sv -----
// Shared types and constants of the keyboard report decoder.
package hkre_pkg;

   // Slot geometry
   localparam int KEY_SLOTS   = 6;
   localparam int SLOT_FIELDS = 6;
   localparam int EVENT_COUNT = 1 + 2 * KEY_SLOTS;

   // Beat layout
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 2;
   localparam int BYTES_W     = 7;
   localparam int BYTES_LSB   = 0;
   localparam int MOD_LSB     = 7;
   localparam int SLOT_LSB    = 15;
   localparam int ASCII_W     = 7;

   // Protocol codes
   localparam logic [BYTES_W-1:0] MIN_REPORT_BYTES = 7'd8;
   localparam logic [7:0] GUI_MASK       = 8'h88;
   localparam logic [7:0] GUI_RIGHT      = 8'h80;
   localparam logic [7:0] CODE_GUI_RIGHT = 8'hE7;
   localparam logic [7:0] CODE_GUI_LEFT  = 8'hE3;
   localparam logic [7:0] NO_KEY_MAX     = 8'h03;

   typedef logic [7:0] key_type;
   typedef key_type [KEY_SLOTS-1:0] key_array_type;

   // One key event before translation
   typedef struct packed {
      key_type    code;
      logic [7:0] modifier;
      logic       is_release;
   } event_type;

   typedef event_type [EVENT_COUNT-1:0] event_array_type;

   // What one lane found for its slot
   typedef struct packed {
      logic rel_hit;
      logic press_hit;
   } lane_flags_type;

endpackage

// ----- hdl/hkre_lane.sv -----
// One slot lane: finds a release of the held key and a press of the new key.
module hkre_lane
   import hkre_pkg::*;
(
   input  key_type        new_key,
   input  key_type        held_key,
   input  key_array_type  new_keys,
   input  key_array_type  held_keys,
   output lane_flags_type flags
);

   logic skip;
   logic held_gone;
   logic new_fresh;

   // Search both reports for this lane's codes
   always_comb begin
      held_gone = 1'b1;
      new_fresh = 1'b1;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (new_keys[j] == held_key) begin
            held_gone = 1'b0;
         end
         if (held_keys[j] == new_key) begin
            new_fresh = 1'b0;
         end
      end
   end

   // Drop the whole slot when its new key is a GUI code
   assign skip = (new_key == CODE_GUI_LEFT) || (new_key == CODE_GUI_RIGHT);

   assign flags.rel_hit   = !skip && (held_key > NO_KEY_MAX) && held_gone;
   assign flags.press_hit = !skip && (new_key > NO_KEY_MAX) && new_fresh;

endmodule

// ----- hdl/hkre_xlate.sv -----
// Shift-aware ASCII translation and text flag for one key event.
module hkre_xlate
   import hkre_pkg::*;
(
   input  event_type          ev,
   output logic [ASCII_W-1:0] ascii_char,
   output logic               text_valid
);

   localparam key_type KEY_A      = 8'h04;
   localparam key_type KEY_Z      = 8'h1D;
   localparam key_type KEY_ONE    = 8'h1E;
   localparam key_type KEY_SLASH  = 8'h38;
   localparam key_type KEY_ENTER  = 8'h28;
   localparam key_type KEY_ESC    = 8'h29;
   localparam key_type KEY_BKSP   = 8'h2A;
   localparam key_type KEY_TAB    = 8'h2B;
   localparam key_type KEY_SPACE  = 8'h2C;
   localparam key_type KEY_DELETE = 8'h4C;
   localparam logic [7:0] SHIFT_BITS = 8'h22;

   // Symbol pair for codes from the digit row on: {shifted, plain}
   function automatic logic [2*ASCII_W-1:0] sym_pair(input logic [4:0] idx);
      logic [2*ASCII_W-1:0] pair;
      case (idx)
         5'd0:    pair = {7'h21, 7'h31};
         5'd1:    pair = {7'h40, 7'h32};
         5'd2:    pair = {7'h23, 7'h33};
         5'd3:    pair = {7'h24, 7'h34};
         5'd4:    pair = {7'h25, 7'h35};
         5'd5:    pair = {7'h5E, 7'h36};
         5'd6:    pair = {7'h26, 7'h37};
         5'd7:    pair = {7'h2A, 7'h38};
         5'd8:    pair = {7'h28, 7'h39};
         5'd9:    pair = {7'h29, 7'h30};
         5'd15:   pair = {7'h5F, 7'h2D};
         5'd16:   pair = {7'h2B, 7'h3D};
         5'd17:   pair = {7'h7B, 7'h5B};
         5'd18:   pair = {7'h7D, 7'h5D};
         5'd19:   pair = {7'h7C, 7'h5C};
         5'd20:   pair = {7'h7C, 7'h5C};
         5'd21:   pair = {7'h3A, 7'h3B};
         5'd22:   pair = {7'h22, 7'h27};
         5'd23:   pair = {7'h7E, 7'h60};
         5'd24:   pair = {7'h3C, 7'h2C};
         5'd25:   pair = {7'h3E, 7'h2E};
         5'd26:   pair = {7'h3F, 7'h2F};
         default: pair = '0;
      endcase
      return pair;
   endfunction

   logic                 shifted;
   logic                 control_key;
   logic                 printable;
   logic [7:0]           letter;
   logic [7:0]           sym_index;
   logic [2*ASCII_W-1:0] pair;
   logic [ASCII_W-1:0]   print_char;
   logic [ASCII_W-1:0]   control_char;

   assign shifted     = |(ev.modifier & SHIFT_BITS);
   assign control_key = (ev.code == KEY_ENTER) || (ev.code == KEY_ESC) ||
                        (ev.code == KEY_BKSP) || (ev.code == KEY_TAB) ||
                        (ev.code == KEY_SPACE) || (ev.code == KEY_DELETE);
   assign printable   = !control_key && (ev.code >= KEY_A) && (ev.code <= KEY_SLASH);

   // Letters run from 'a' or 'A'; the rest come from the symbol table
   assign letter     = (shifted ? 8'h41 : 8'h61) + (ev.code - KEY_A);
   assign sym_index  = ev.code - KEY_ONE;
   assign pair       = sym_pair(sym_index[4:0]);
   assign print_char = (ev.code <= KEY_Z) ? letter[ASCII_W-1:0] :
                       (shifted ? pair[2*ASCII_W-1:ASCII_W] : pair[ASCII_W-1:0]);

   // Map control keys
   always_comb begin
      case (ev.code)
         KEY_ENTER:  control_char = 7'h0D;
         KEY_TAB:    control_char = 7'h09;
         KEY_BKSP:   control_char = 7'h08;
         KEY_SPACE:  control_char = 7'h20;
         KEY_ESC:    control_char = 7'h1B;
         KEY_DELETE: control_char = 7'h7F;
         default:    control_char = '0;
      endcase
   end

   assign ascii_char = printable ? print_char : control_char;
   assign text_valid = printable && !ev.is_release;

endmodule

// ----- hdl/hkre_merge.sv -----
// Merge stage: holds the lanes' candidate events and sends them out in order.
module hkre_merge
   import hkre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  event_array_type        cand,
   input  logic [EVENT_COUNT-1:0] cand_mask,
   output logic                   busy,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   output logic                   rsp_tlast
);

   event_array_type        cand_ff;
   logic [EVENT_COUNT-1:0] mask_ff, mask_in;
   logic [EVENT_COUNT-1:0] pick_onehot;
   event_type              pick_ev;
   logic                   pick_last;
   logic                   pop;
   logic [ASCII_W-1:0]     pick_ascii;
   logic                   pick_text;

   logic                   out_valid_ff, out_valid_in;
   event_type              out_ev_ff;
   logic [ASCII_W-1:0]     out_ascii_ff;
   logic                   out_text_ff;
   logic                   out_last_ff;

   // Pick the lowest pending candidate
   assign pick_onehot = mask_ff & (~mask_ff + 1'b1);
   assign pick_last   = (mask_ff & ~pick_onehot) == '0;

   always_comb begin
      pick_ev = '0;
      for (int i = 0; i < EVENT_COUNT; i++) begin
         if (pick_onehot[i]) begin
            pick_ev = pick_ev | cand_ff[i];
         end
      end
   end

   hkre_xlate u_xlate (
      .ev         (pick_ev),
      .ascii_char (pick_ascii),
      .text_valid (pick_text)
   );

   // Advance when the output register is free or being emptied
   assign pop  = (mask_ff != '0) && (!out_valid_ff || rsp_tready);
   assign busy = mask_ff != '0;

   always_comb begin
      if (load) begin
         mask_in = cand_mask;
      end else if (pop) begin
         mask_in = mask_ff & ~pick_onehot;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: candidates on load, output beat on pop
   always_ff @(posedge clock) begin
      if (load) begin
         cand_ff <= cand;
      end
      if (pop) begin
         out_ev_ff    <= pick_ev;
         out_ascii_ff <= pick_ascii;
         out_text_ff  <= pick_text;
         out_last_ff  <= pick_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ascii_ff, out_ev_ff.modifier, out_ev_ff.code};
   assign rsp_tuser  = {out_text_ff, out_ev_ff.is_release};
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hdl/hid_keyboard_report_to_key_events.sv -----
// Top level of the boot keyboard report decoder.
//
// req_* takes one boot keyboard report per beat: byte count, modifier byte
// and six key slots. Reports shorter than eight bytes are dropped at once.
// rsp_* gives key press and release events, one per beat, with the usage
// code, the attached modifier, an ASCII translation and a text flag.
// A GUI modifier change comes first, then releases and presses slot by
// slot; tlast marks the final event of a report, and a report that
// changes nothing gives no beat at all.
// rsp_tvalid rises once the report is registered and its first event has
// passed into the output register. Events leave at one per cycle while the
// receiver is ready; the serializer in the merge stage holds the input
// closed, and req_tready rises again as the final event enters the output
// register, so the next report can be taken while that event waits.
// A stalled receiver holds the output beat and the serializer.
// Reset clears the held keys and modifier and drops any pending events.
module hid_keyboard_report_to_key_events
   import hkre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // report_bytes[6:0], modifier_bits[14:7], key_slot_0..5[62:15], pad[63]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // usage[7:0], event_modifier[15:8], ascii_char[22:16], pad[23]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // is_release[0], text_valid[1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   key_array_type          held_keys_ff;
   logic [7:0]             held_mod_ff;
   key_array_type          new_keys;
   logic [7:0]             new_mod;
   logic [BYTES_W-1:0]     report_bytes;
   logic                   load;
   logic                   busy;
   lane_flags_type         lane_flags [KEY_SLOTS];
   event_array_type        cand;
   logic [EVENT_COUNT-1:0] cand_mask;

   assign report_bytes = req_tdata[BYTES_LSB +: BYTES_W];
   assign new_mod      = req_tdata[MOD_LSB +: 8];
   assign req_tready   = !busy;
   assign load         = req_tvalid && req_tready && (report_bytes >= MIN_REPORT_BYTES);

   // Unpack slots; slots past the beat read as no key
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
      if (i < SLOT_FIELDS) begin : g_live
         assign new_keys[i] = req_tdata[SLOT_LSB + 8*i +: 8];
      end else begin : g_none
         assign new_keys[i] = '0;
      end
   end

   // Lanes and their candidate events
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
      hkre_lane u_lane (
         .new_key   (new_keys[i]),
         .held_key  (held_keys_ff[i]),
         .new_keys  (new_keys),
         .held_keys (held_keys_ff),
         .flags     (lane_flags[i])
      );
      assign cand[1 + 2*i]      = '{code: held_keys_ff[i], modifier: 8'h00, is_release: 1'b1};
      assign cand_mask[1 + 2*i] = lane_flags[i].rel_hit;
      assign cand[2 + 2*i]      = '{code: new_keys[i], modifier: new_mod, is_release: 1'b0};
      assign cand_mask[2 + 2*i] = lane_flags[i].press_hit;
   end

   // GUI modifier event leads the report
   assign cand[0].code       = ((new_mod & GUI_RIGHT) != '0) ? CODE_GUI_RIGHT : CODE_GUI_LEFT;
   assign cand[0].modifier   = new_mod;
   assign cand[0].is_release = (new_mod & GUI_MASK) == '0;
   assign cand_mask[0]       = (new_mod & GUI_MASK) != (held_mod_ff & GUI_MASK);

   // Remember the last full report
   always_ff @(posedge clock) begin
      if (reset) begin
         held_keys_ff <= '0;
         held_mod_ff  <= '0;
      end else if (load) begin
         held_keys_ff <= new_keys;
         held_mod_ff  <= new_mod;
      end
   end

   hkre_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .cand       (cand),
      .cand_mask  (cand_mask),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hdl/hkre_checker.sv -----
// Port checker for the keyboard report decoder, bound to the top level.
`include "hid_keyboard_report_to_key_events_assert.svh"

module hkre_checker
   import hkre_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // Hold a stalled event beat
   `HKRE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled event beat changed")

   // A short report leaves the input open
   `HKRE_ASSERT_NEXT(a_short_open, req_tvalid && req_tready && (req_tdata[BYTES_LSB +: BYTES_W] < MIN_REPORT_BYTES), req_tready, "short report blocked the input")

   // More events pending: the input stays closed
   `HKRE_ASSERT_NOW(a_pending_closed, rsp_tvalid && !rsp_tlast, !req_tready, "input open while events remain")

endmodule

bind hid_keyboard_report_to_key_events hkre_checker u_checker (.*);
